// ===== hw/rtl/idba_pkg.sv =====
// shared constants and types for the agreed identifier bitmap allocator
package idba_pkg;

    // width of one free-map word and of the incoming peer word
    localparam int unsigned WORD_W = 32;
    // width of a bit index within a word
    localparam int unsigned BIT_W = 5;
    // width of a granted identifier
    localparam int unsigned ID_W = 12;
    // width of the result tdata bus (identifier padded to whole bytes)
    localparam int unsigned OUT_TDATA_W = 16;

    // reset contents of the free map
    localparam logic [WORD_W-1:0] WORD0_RESET = 32'h3FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_RESET  = 32'hFFFF_FFFF;

    // end-of-round result handed from the scan stage to the output register
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] granted_id;
        logic            exhausted;
    } result_t;

endpackage

// ===== hw/rtl/agreed_id_bitmap_allocator.sv =====
// top level of the agreed identifier bitmap allocator
//
//  channel | dir | ports                          | word
//  --------+-----+--------------------------------+-------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[31:0] | one peer mask word per item
//  m_      | out | m_tvalid m_tready m_tdata m_tuser | one result per round
//
//  one word is taken per cycle while s_tready is high; it is read and scanned in the next cycle,
//  which ends by loading the result register, so m_tvalid rises once the last word is scanned
//  a round is MAP_WORDS words; with a single-word map the one-slot result register
//  admits no new word while the previous one is still being scanned
//  the last word of a round waits while the result register is still held
//  reset is immediate: map words read as their reset contents until first written
module agreed_id_bitmap_allocator #(
    parameter int unsigned MAP_WORDS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [idba_pkg::WORD_W-1:0]         s_tdata,   // [31:0] peer_word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [idba_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [11:0] granted_id, [15:12] zero
    output logic                                m_tuser    // [0] exhausted
);

    localparam int unsigned ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [ADDR_W-1:0]           pos_reg;
    logic [ADDR_W-1:0]           pos_next;
    logic                        pos_last;
    logic                        accept;

    logic                        out_valid_reg;
    logic [idba_pkg::ID_W-1:0]   out_id_reg;
    logic                        out_exh_reg;

    logic [idba_pkg::WORD_W-1:0] map_word;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [idba_pkg::WORD_W-1:0] wr_data;
    idba_pkg::result_t           result;

    // word position within the round
    always_comb begin
        pos_last = (pos_reg == ADDR_W'(MAP_WORDS - 1));
        pos_next = pos_last ? '0 : pos_reg + ADDR_W'(1);
    end

    // last word only enters when the result register is sure to be free
    always_comb begin
        s_tready = !pos_last || ((!out_valid_reg || m_tready) && !result.valid);
        accept   = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    idba_map_ram #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_word (map_word)
    );

    idba_scan #(
        .ADDR_W (ADDR_W)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_take      (accept),
        .in_pos       (pos_reg),
        .in_last      (pos_last),
        .in_peer_word (s_tdata),
        .map_word     (map_word),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .result       (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (result.valid) begin
            out_id_reg  <= result.granted_id;
            out_exh_reg <= result.exhausted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = idba_pkg::OUT_TDATA_W'(out_id_reg);
    assign m_tuser  = out_exh_reg;

endmodule

// ===== hw/rtl/idba_map_ram.sv =====
// free-map word memory with per-word valid bits and write-to-read forwarding
module idba_map_ram #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [idba_pkg::WORD_W-1:0]    wr_data,
    output logic [idba_pkg::WORD_W-1:0]    rd_word
);

    logic [idba_pkg::WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [idba_pkg::WORD_W-1:0] mem_q_reg;
    logic                        rd_valid_reg;
    logic [ADDR_W-1:0]           rd_addr_reg;
    logic                        fwd_hit_reg;
    logic [idba_pkg::WORD_W-1:0] fwd_data_reg;

    // memory array: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // valid bits, cleared at reset, and the same-word forwarding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // effective word: forwarded write, stored word, or reset contents
    always_comb begin
        if (fwd_hit_reg) begin
            rd_word = fwd_data_reg;
        end else if (rd_valid_reg) begin
            rd_word = mem_q_reg;
        end else if (rd_addr_reg == '0) begin
            rd_word = idba_pkg::WORD0_RESET;
        end else begin
            rd_word = idba_pkg::WORD_RESET;
        end
    end

endmodule

// ===== hw/rtl/idba_scan.sv =====
// scan stage: and with peer word, leading-bit search, map update and round tracking
module idba_scan #(
    parameter int unsigned ADDR_W = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_take,
    input  logic [ADDR_W-1:0]              in_pos,
    input  logic                           in_last,
    input  logic [idba_pkg::WORD_W-1:0]    in_peer_word,
    input  logic [idba_pkg::WORD_W-1:0]    map_word,
    output logic                           wr_en,
    output logic [ADDR_W-1:0]              wr_addr,
    output logic [idba_pkg::WORD_W-1:0]    wr_data,
    output idba_pkg::result_t              result
);

    localparam int unsigned FULL_ID_W = ADDR_W + idba_pkg::BIT_W + 2;

    logic                        s1_valid_reg;
    logic [ADDR_W-1:0]           s1_pos_reg;
    logic                        s1_last_reg;
    logic [idba_pkg::WORD_W-1:0] s1_peer_reg;
    logic                        found_reg;
    logic [idba_pkg::ID_W-1:0]   pending_reg;

    logic [idba_pkg::WORD_W-1:0] common;
    logic [idba_pkg::BIT_W-1:0]  lead_bit;
    logic                        take;
    logic [FULL_ID_W-1:0]        full_id;
    logic                        found_next;
    logic [idba_pkg::ID_W-1:0]   pending_next;

    // word stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_take;
        end
        if (in_take) begin
            s1_pos_reg  <= in_pos;
            s1_last_reg <= in_last;
            s1_peer_reg <= in_peer_word;
        end
    end

    // leading set bit, counted from the msb
    always_comb begin
        common   = s1_peer_reg & map_word;
        lead_bit = '0;
        for (int i = 0; i < int'(idba_pkg::WORD_W); i++) begin
            if (common[i]) begin
                lead_bit = idba_pkg::BIT_W'(idba_pkg::WORD_W - 1 - i);
            end
        end
    end

    // first common bit of the round is taken and cleared locally
    always_comb begin
        take         = s1_valid_reg && !found_reg && (common != '0);
        full_id      = {s1_pos_reg, lead_bit, 2'b00};
        found_next   = found_reg | take;
        pending_next = take ? idba_pkg::ID_W'(full_id) : pending_reg;
        wr_en        = take;
        wr_addr      = s1_pos_reg;
        wr_data      = map_word & ~({1'b1, {(idba_pkg::WORD_W-1){1'b0}}} >> lead_bit);
    end

    // end-of-round result
    always_comb begin
        result.valid      = s1_valid_reg && s1_last_reg;
        result.granted_id = found_next ? pending_next : '0;
        result.exhausted  = !found_next;
    end

    // round state, cleared after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            pending_reg <= '0;
        end else if (s1_valid_reg) begin
            if (s1_last_reg) begin
                found_reg   <= 1'b0;
                pending_reg <= '0;
            end else begin
                found_reg   <= found_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule
